// File: rtl/core/sweep_waveform_sample_generator_assert.svh
// assertion macros used by the sweep waveform sample generator checker
`ifndef SWEEP_WAVEFORM_SAMPLE_GENERATOR_ASSERT_SVH
`define SWEEP_WAVEFORM_SAMPLE_GENERATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWSG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent after the delay given by argument n
`define SWSG_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// File: rtl/core/swsg_pkg.sv
// shared types and constants of the sweep waveform sample generator
package swsg_pkg;

	localparam int IDX_W  = 12;
	localparam int AMP_W  = 16;
	localparam int VAL_W  = 17;
	localparam int LEN_W  = 13;
	localparam int PEAK_W = 16;
	localparam int T_W    = 16;
	localparam int MAG_W  = 17;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int MAX_CYCLE_SAMPLES      = 4096;
	localparam int SINE_TABLE_ENTRIES_DEF = 1024;
	localparam int OUT_LIMIT              = 65535;

	// phase divider: quotient bits resolved per pipeline stage
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES         = T_W / DIV_BITS_PER_STAGE;

	// input stage + divider + wave (2) + scale (3)
	localparam int PIPE_LATENCY = 1 + DIV_STAGES + 2 + 3;

	typedef enum logic [1:0] {
		WAVE_SINE,
		WAVE_TRI,
		WAVE_RAMP,
		WAVE_ZERO
	} wave_mode_t;

	// control that travels alongside each item
	typedef struct packed {
		logic             vld;
		logic             err;
		logic [AMP_W-1:0] amp;
	} tag_t;

endpackage

// File: rtl/core/sweep_waveform_sample_generator.sv
// top level of the sweep waveform sample generator: config port and pipeline
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ---------------------------------
// item      in         start high, busy low       sample_index, amplitude
// result    out        done strobe, one cycle     sample_value, index_error
// config    in         psel & penable & pwrite    paddr, pwdata (prdata on reads)
//
// one item per clock; busy never rises, so a transfer may be offered every cycle
// each result passes through the input register, the phase divider
// (16 quotient bits at four per stage), the sine rom read and two multiplies
// asynchronous reset returns config to its reset values and clears all valid bits
// the receiver cannot stall: done is high for exactly one cycle per result
module sweep_waveform_sample_generator #(
	parameter int SINE_TABLE_ENTRIES = swsg_pkg::SINE_TABLE_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item transfer
	input  logic                               start,
	output logic                               busy,
	input  logic [swsg_pkg::IDX_W-1:0]         sample_index,
	input  logic [swsg_pkg::AMP_W-1:0]         amplitude,
	// result transfer
	output logic                               done,
	output logic signed [swsg_pkg::VAL_W-1:0]  sample_value,
	output logic                               index_error,
	// config port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [swsg_pkg::ADDR_W-1:0]        paddr,
	input  logic [swsg_pkg::DATA_W-1:0]        pwdata,
	output logic [swsg_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	localparam int LEN_W  = swsg_pkg::LEN_W;
	localparam int DATA_W = swsg_pkg::DATA_W;

	// register word indexes
	localparam logic [1:0] REG_WAVE_MODE    = 2'd0;
	localparam logic [1:0] REG_PEAK_CURRENT = 2'd1;
	localparam logic [1:0] REG_CYCLE_LENGTH = 2'd2;

	localparam logic [swsg_pkg::PEAK_W-1:0] PEAK_RST = 16'd4096;
	localparam logic [LEN_W-1:0]            LEN_RST  = 13'd1024;

	// config registers
	swsg_pkg::wave_mode_t             wave_mode_q;
	logic [swsg_pkg::PEAK_W-1:0]      peak_current_q;
	logic [LEN_W-1:0]                 cycle_length_q;

	logic                             cfg_wr;
	logic [1:0]                       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[swsg_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= swsg_pkg::WAVE_SINE;
			peak_current_q <= PEAK_RST;
			cycle_length_q <= LEN_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WAVE_MODE:    wave_mode_q    <= swsg_pkg::wave_mode_t'(pwdata[1:0]);
				REG_PEAK_CURRENT: peak_current_q <= pwdata[swsg_pkg::PEAK_W-1:0];
				REG_CYCLE_LENGTH: cycle_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_WAVE_MODE:    prdata = DATA_W'(wave_mode_q);
			REG_PEAK_CURRENT: prdata = DATA_W'(peak_current_q);
			REG_CYCLE_LENGTH: prdata = DATA_W'(cycle_length_q);
			default:          prdata = '0;
		endcase
	end

	// cycle lengths above the supported maximum act as the maximum
	logic [LEN_W-1:0] len_eff;

	assign len_eff = (32'(cycle_length_q) > swsg_pkg::MAX_CYCLE_SAMPLES)
		? LEN_W'(swsg_pkg::MAX_CYCLE_SAMPLES) : cycle_length_q;

	// stage 1: capture the item and flag an index past the cycle end
	// (a zero length flags every index)
	logic                              accept;
	logic                              idx_err;
	swsg_pkg::tag_t                    tag_s1;
	logic [swsg_pkg::IDX_W-1:0]        idx_s1;

	assign busy    = 1'b0;
	assign accept  = start & ~busy;
	assign idx_err = ({1'b0, sample_index} >= len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= accept;
			tag_s1.err <= idx_err;
			tag_s1.amp <= amplitude;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= sample_index;
	end

	// stages 2-5: phase t = index * 65536 / length
	swsg_pkg::tag_t                    div_tag;
	logic [swsg_pkg::T_W-1:0]          div_t;

	swsg_phase_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_tag  (tag_s1),
		.in_idx  (idx_s1),
		.len     (len_eff),
		.out_tag (div_tag),
		.out_t   (div_t)
	);

	// stages 6-7: wave value as sign and magnitude
	swsg_pkg::tag_t                    wave_tag;
	logic [swsg_pkg::MAG_W-1:0]        wave_mag;
	logic                              wave_neg;

	swsg_wave #(
		.SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
	) u_wave (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_tag  (div_tag),
		.t       (div_t),
		.mode    (wave_mode_q),
		.out_tag (wave_tag),
		.mag     (wave_mag),
		.neg     (wave_neg)
	);

	// stages 8-10: peak current and envelope scaling, rounding, output register
	swsg_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_tag       (wave_tag),
		.mag          (wave_mag),
		.neg          (wave_neg),
		.peak         (peak_current_q),
		.done         (done),
		.sample_value (sample_value),
		.index_error  (index_error)
	);

endmodule

// File: rtl/core/swsg_phase_div.sv
// pipelined restoring divider forming the q0.16 phase index*65536/length
module swsg_phase_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swsg_pkg::tag_t               in_tag,
	input  logic [swsg_pkg::IDX_W-1:0]   in_idx,
	input  logic [swsg_pkg::LEN_W-1:0]   len,
	output swsg_pkg::tag_t               out_tag,
	output logic [swsg_pkg::T_W-1:0]     out_t
);

	localparam int REM_W  = swsg_pkg::LEN_W + 1;
	localparam int STAGES = swsg_pkg::DIV_STAGES;
	localparam int STEPS  = swsg_pkg::DIV_BITS_PER_STAGE;
	localparam int T_W    = swsg_pkg::T_W;

	// index 0 is the stage input, 1..STAGES are registers
	swsg_pkg::tag_t     tag_s [STAGES+1];
	logic [REM_W-1:0]   rem_s [STAGES+1];
	logic [T_W-1:0]     quo_s [STAGES+1];

	logic [REM_W-1:0]   len_ext;

	assign len_ext  = {1'b0, len};
	assign tag_s[0] = in_tag;
	assign rem_s[0] = REM_W'(in_idx);
	assign quo_s[0] = '0;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [REM_W-1:0] rem_nxt;
		logic [T_W-1:0]   quo_nxt;

		always_comb begin
			logic [REM_W-1:0] r2;
			rem_nxt = rem_s[g];
			quo_nxt = quo_s[g];
			for (int j = 0; j < STEPS; j++) begin
				r2 = {rem_nxt[REM_W-2:0], 1'b0};
				if (r2 >= len_ext) begin
					rem_nxt = r2 - len_ext;
					quo_nxt = {quo_nxt[T_W-2:0], 1'b1};
				end else begin
					rem_nxt = r2;
					quo_nxt = {quo_nxt[T_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[g+1] <= '0;
			end else begin
				tag_s[g+1] <= tag_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_nxt;
			quo_s[g+1] <= quo_nxt;
		end
	end

	assign out_tag = tag_s[STAGES];
	assign out_t   = quo_s[STAGES];

endmodule

// File: rtl/core/swsg_wave.sv
// wave shaping: sine quarter-wave rom, triangle and ramp, sign and magnitude
module swsg_wave #(
	parameter int SINE_TABLE_ENTRIES = swsg_pkg::SINE_TABLE_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  swsg_pkg::tag_t               in_tag,
	input  logic [swsg_pkg::T_W-1:0]     t,
	input  swsg_pkg::wave_mode_t         mode,
	output swsg_pkg::tag_t               out_tag,
	output logic [swsg_pkg::MAG_W-1:0]   mag,
	output logic                         neg
);

	localparam int T_W    = swsg_pkg::T_W;
	localparam int MAG_W  = swsg_pkg::MAG_W;
	localparam int FOUR_N = 4 * SINE_TABLE_ENTRIES;
	localparam int POS_W  = $clog2(FOUR_N);
	localparam int PROD_W = T_W + POS_W;
	localparam int E_W    = $clog2(SINE_TABLE_ENTRIES + 1);

	localparam logic [POS_W-1:0] QTR1 = POS_W'(SINE_TABLE_ENTRIES);
	localparam logic [POS_W-1:0] QTR2 = POS_W'(2 * SINE_TABLE_ENTRIES);
	localparam logic [POS_W-1:0] QTR3 = POS_W'(3 * SINE_TABLE_ENTRIES);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [MAG_W-1:0] rom_t [SINE_TABLE_ENTRIES+1];

	// round(65536 * sin(x)), x in q30, 0 <= x <= pi/2, by a fixed series
	function automatic logic [MAG_W-1:0] sine_q16(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - $signed(term);
		if (sum < 0) begin
			sum = '0;
		end
		v = ($unsigned(sum) + 64'd8192) >> 14;
		if (v > 64'd65536) begin
			v = 64'd65536;
		end
		return v[MAG_W-1:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
			x = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_ENTRIES / 2))
				/ 64'(SINE_TABLE_ENTRIES);
			r[k] = sine_q16(x);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// stage 6: table address and linear waves
	logic [PROD_W-1:0]      prod;
	logic [POS_W-1:0]       pos;
	logic [POS_W-1:0]       rem;
	logic [1:0]             quad;
	logic [E_W-1:0]         addr;
	logic [T_W+1:0]         t4;
	logic signed [T_W+2:0]  tri_w;
	logic [T_W+1:0]         ramp_w;
	logic [T_W+2:0]         tri_abs;
	logic [MAG_W-1:0]       lin_mag;
	logic                   lin_neg;

	always_comb begin
		prod = PROD_W'(t) * PROD_W'(FOUR_N);
		pos  = prod[PROD_W-1 -: POS_W];
		if (pos >= QTR3) begin
			quad = 2'd3;
		end else if (pos >= QTR2) begin
			quad = 2'd2;
		end else if (pos >= QTR1) begin
			quad = 2'd1;
		end else begin
			quad = 2'd0;
		end
		case (quad)
			2'd0:    rem = pos;
			2'd1:    rem = pos - QTR1;
			2'd2:    rem = pos - QTR2;
			default: rem = pos - QTR3;
		endcase
		addr = quad[0] ? (E_W'(SINE_TABLE_ENTRIES) - E_W'(rem)) : E_W'(rem);

		// triangle: 4t - 1 on the rising half, 3 - 4t on the falling half
		t4 = {t, 2'b00};
		if (t[T_W-1]) begin
			tri_w = $signed(19'd196608) - $signed({1'b0, t4});
		end else begin
			tri_w = $signed({1'b0, t4}) - $signed(19'd65536);
		end
		tri_abs = tri_w[T_W+2] ? (~tri_w + 1'b1) : tri_w;

		// unipolar ramp: 2t, then 2 - 2t
		if (t[T_W-1]) begin
			ramp_w = 18'd131072 - {1'b0, t, 1'b0};
		end else begin
			ramp_w = {1'b0, t, 1'b0};
		end

		case (mode)
			swsg_pkg::WAVE_TRI: begin
				lin_mag = tri_abs[MAG_W-1:0];
				lin_neg = tri_w[T_W+2];
			end
			swsg_pkg::WAVE_RAMP: begin
				lin_mag = ramp_w[MAG_W-1:0];
				lin_neg = 1'b0;
			end
			default: begin
				lin_mag = '0;
				lin_neg = 1'b0;
			end
		endcase
	end

	swsg_pkg::tag_t     tag_s6;
	logic [E_W-1:0]     addr_s6;
	logic [MAG_W-1:0]   lin_mag_s6;
	logic               neg_s6;
	logic               use_rom_s6;

	swsg_pkg::tag_t     tag_s7;
	logic [MAG_W-1:0]   rom_s7;
	logic [MAG_W-1:0]   lin_mag_s7;
	logic               neg_s7;
	logic               use_rom_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else begin
			tag_s6 <= in_tag;
			tag_s7 <= tag_s6;
		end
	end

	always_ff @(posedge clk) begin
		addr_s6    <= addr;
		lin_mag_s6 <= lin_mag;
		use_rom_s6 <= (mode == swsg_pkg::WAVE_SINE);
		neg_s6     <= (mode == swsg_pkg::WAVE_SINE) ? quad[1] : lin_neg;
		rom_s7     <= SINE_ROM[addr_s6];
		lin_mag_s7 <= lin_mag_s6;
		use_rom_s7 <= use_rom_s6;
		neg_s7     <= neg_s6;
	end

	assign out_tag = tag_s7;
	assign mag     = use_rom_s7 ? rom_s7 : lin_mag_s7;
	assign neg     = neg_s7;

endmodule

// File: rtl/core/swsg_scale.sv
// scaling by peak current and amplitude, rounding, saturation and sign
module swsg_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swsg_pkg::tag_t                    in_tag,
	input  logic [swsg_pkg::MAG_W-1:0]        mag,
	input  logic                              neg,
	input  logic [swsg_pkg::PEAK_W-1:0]       peak,
	output logic                              done,
	output logic signed [swsg_pkg::VAL_W-1:0] sample_value,
	output logic                              index_error
);

	localparam int P1_W  = swsg_pkg::MAG_W + swsg_pkg::PEAK_W;
	localparam int P2_W  = P1_W + swsg_pkg::AMP_W;
	localparam int VAL_W = swsg_pkg::VAL_W;
	localparam int RND_W = P2_W - 31;

	swsg_pkg::tag_t     tag_s8;
	logic [P1_W-1:0]    prod_s8;
	logic               neg_s8;

	logic               vld_s9;
	logic               err_s9;
	logic [P2_W-1:0]    prod_s9;
	logic               neg_s9;

	logic               vld_s10;
	logic               err_s10;
	logic [VAL_W-1:0]   val_s10;

	logic [P2_W-1:0]    rnd;
	logic [RND_W-1:0]   rnd_mag;
	logic [VAL_W-2:0]   sat_mag;
	logic [VAL_W-1:0]   val;

	always_comb begin
		rnd     = prod_s9 + P2_W'(64'd1 << 30);
		rnd_mag = rnd[P2_W-1:31];
		sat_mag = (rnd_mag > RND_W'(swsg_pkg::OUT_LIMIT))
			? (VAL_W-1)'(swsg_pkg::OUT_LIMIT) : rnd_mag[VAL_W-2:0];
		if (err_s9) begin
			val = '0;
		end else if (neg_s9) begin
			val = '0 - {1'b0, sat_mag};
		end else begin
			val = {1'b0, sat_mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s8  <= '0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			tag_s8  <= in_tag;
			vld_s9  <= tag_s8.vld;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		prod_s8 <= P1_W'(mag) * P1_W'(peak);
		neg_s8  <= neg;
		prod_s9 <= P2_W'(prod_s8) * P2_W'(tag_s8.amp);
		neg_s9  <= neg_s8;
		err_s9  <= tag_s8.err;
		val_s10 <= val;
		err_s10 <= err_s9;
	end

	assign done         = vld_s10;
	assign sample_value = $signed(val_s10);
	assign index_error  = err_s10;

endmodule

// File: rtl/core/swsg_check.sv
// port-level checker for the sweep waveform sample generator, with its bind
`include "sweep_waveform_sample_generator_assert.svh"

module swsg_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic signed [swsg_pkg::VAL_W-1:0]  sample_value,
	input logic                               index_error
);

	localparam int Lat = swsg_pkg::PIPE_LATENCY;

	logic accept;

	assign accept = start & ~busy;

	`SWSG_ASSERT_DELAY(a_result_follows, clk, arst_n, accept, Lat, done, "transfer lost")
	`SWSG_ASSERT_IMP(a_result_has_cause, clk, arst_n, done, $past(accept, Lat), "result invented")
	`SWSG_ASSERT_IMP(a_error_zero, clk, arst_n, done && index_error, sample_value == '0, "flagged result not zero")
	`SWSG_ASSERT_IMP(a_saturated, clk, arst_n, done, !(sample_value[16] && (sample_value[15:0] == '0)), "result beyond clamp")

endmodule

bind sweep_waveform_sample_generator swsg_check u_check (.*);

// File: tb/tb_sweep_waveform_sample_generator.sv
// self-checking testbench of the sweep waveform sample generator, with its own sample predictor
module tb_sweep_waveform_sample_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W             = swsg_pkg::IDX_W;
	localparam int AMP_W             = swsg_pkg::AMP_W;
	localparam int VAL_W             = swsg_pkg::VAL_W;
	localparam int ADDR_W            = swsg_pkg::ADDR_W;
	localparam int DATA_W            = swsg_pkg::DATA_W;
	localparam int PEAK_W            = swsg_pkg::PEAK_W;
	localparam int LEN_W             = swsg_pkg::LEN_W;
	localparam int MAX_CYCLE_SAMPLES = swsg_pkg::MAX_CYCLE_SAMPLES;
	localparam int OUT_LIMIT         = swsg_pkg::OUT_LIMIT;
	localparam int PIPE_LATENCY      = swsg_pkg::PIPE_LATENCY;

	typedef swsg_pkg::wave_mode_t wave_mode_t;
	typedef longint unsigned      u64_t;

	// quarter-wave table size used by both the block and the predictor
	localparam int SINE_N = swsg_pkg::SINE_TABLE_ENTRIES_DEF;
	// pi/2 in Q30, the argument scale of the table series
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// register byte addresses (all registers fit in 32 bits, so 4 bytes apart)
	localparam logic [ADDR_W-1:0] REG_WAVE_MODE    = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] REG_PEAK_CURRENT = ADDR_W'(4);
	localparam logic [ADDR_W-1:0] REG_CYCLE_LENGTH = ADDR_W'(8);

	// cycles with no transfer of any kind before the run is declared hung
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 12;
	localparam int ITEMS_PER_PHASE = 90;

	// one pending item: payload plus the idle cycles the sender waits before it
	typedef struct {
		logic [IDX_W-1:0] idx;
		logic [AMP_W-1:0] amp;
		int               gap;
	} sample_req_t;

	// one expected result
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             err;
	} sample_exp_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [IDX_W-1:0]         sample_index = '0;
	logic [AMP_W-1:0]         amplitude = '0;
	logic                     done;
	logic signed [VAL_W-1:0]  sample_value;
	logic                     index_error;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [DATA_W-1:0]        pwdata = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	sweep_waveform_sample_generator #(
		.SINE_TABLE_ENTRIES(SINE_N)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.sample_index(sample_index),
		.amplitude   (amplitude),
		.done        (done),
		.sample_value(sample_value),
		.index_error (index_error),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// predictor copy of the configuration, reset values
	wave_mode_t       cfg_mode = swsg_pkg::WAVE_SINE;
	logic [PEAK_W-1:0] cfg_peak = 16'd4096;
	logic [LEN_W-1:0]  cfg_len  = 13'd1024;

	int unsigned quarter_sine [0:SINE_N];

	sample_req_t sample_req_q[$];
	sample_exp_t expected_sample_q[$];

	// bookkeeping
	int  n_queued = 0;
	int  n_accepted = 0;
	int  n_results = 0;
	int  n_out_of_range = 0;
	int  n_clamped = 0;
	int  n_settings = 1;
	int  fail_count = 0;
	int  mode_hits [4] = '{0, 0, 0, 0};
	int  stall_cycles = 0;
	bit  burst_mode = 1'b0;

	// driver state
	sample_req_t cur_req;
	bit          have_req = 1'b0;
	bit          next_start;
	logic        in_xfer = 1'b0;
	sample_exp_t oldest_sample;

	initial begin
		forever #5 clk = ~clk;
	end

	// round(65536 * sin(x)) for x in Q30 by a truncated integer series
	function automatic int unsigned sine_series_q16(longint unsigned x);
		longint unsigned x2, term, v;
		longint          acc;
		int              n;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		v = (u64_t'(acc) + (64'd1 << 13)) >> 14;
		if (v > 65536)
			v = 65536;
		return 32'(v);
	endfunction

	// expected result of one sample under the current register settings
	function automatic sample_exp_t predict_sample(logic [IDX_W-1:0] idx,
			logic [AMP_W-1:0] amp);
		sample_exp_t     r;
		longint unsigned eff, t, pos, quad, rem, mag;
		longint          w;
		bit              neg;
		eff = (cfg_len > MAX_CYCLE_SAMPLES) ? MAX_CYCLE_SAMPLES : cfg_len;
		r.value = '0;
		r.err = 1'b1;
		// zero length lands here too: every index is out of range
		if (u64_t'(idx) >= eff)
			return r;
		// phase as a Q0.16 fraction of the cycle, truncated
		t = (u64_t'(idx) << 16) / eff;
		case (cfg_mode)
			swsg_pkg::WAVE_SINE: begin
				pos = (t * 4 * SINE_N) >> 16;
				quad = pos / SINE_N;
				rem = pos % SINE_N;
				w = quarter_sine[(quad[0]) ? (SINE_N - rem) : rem];
				if (quad[1])
					w = -w;
			end
			swsg_pkg::WAVE_TRI: begin
				w = (t < 32768) ? longint'(4 * t) - 65536 : 196608 - longint'(4 * t);
			end
			swsg_pkg::WAVE_RAMP: begin
				w = (t < 32768) ? longint'(2 * t) : 131072 - longint'(2 * t);
			end
			default: begin
				w = 0;
			end
		endcase
		// magnitude rounded half away from zero, then clamped
		neg = (w < 0);
		mag = neg ? u64_t'(-w) : u64_t'(w);
		mag = (mag * cfg_peak * amp + (64'd1 << 30)) >> 31;
		if (mag > OUT_LIMIT)
			mag = OUT_LIMIT;
		r.value = neg ? (17'd0 - mag[VAL_W-1:0]) : mag[VAL_W-1:0];
		r.err = 1'b0;
		return r;
	endfunction

	// sender: items change on the falling edge, a held item stays until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			next_start = start && !in_xfer;
			if (!next_start) begin
				if (!have_req && sample_req_q.size() != 0) begin
					cur_req = sample_req_q.pop_front();
					have_req = 1'b1;
				end
				if (have_req) begin
					if (cur_req.gap == 0) begin
						next_start = 1'b1;
						sample_index <= cur_req.idx;
						amplitude <= cur_req.amp;
						have_req = 1'b0;
					end else begin
						cur_req.gap--;
					end
				end
			end
			start <= next_start;
		end
	end

	// monitor: item transfers are predicted, result transfers are checked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_xfer <= 1'b0;
		end else begin
			if (done) begin
				n_results++;
				if (expected_sample_q.size() == 0) begin
					$error("result with no sample waiting: sample_value %0d index_error %0b",
						sample_value, index_error);
					fail_count++;
				end else begin
					oldest_sample = expected_sample_q.pop_front();
					if (sample_value !== oldest_sample.value) begin
						$error("sample_value mismatch: expected %0d, actual %0d",
							$signed(oldest_sample.value), sample_value);
						fail_count++;
					end
					if (index_error !== oldest_sample.err) begin
						$error("index_error mismatch: expected %0b, actual %0b",
							oldest_sample.err, index_error);
						fail_count++;
					end
				end
			end
			in_xfer <= start && !busy;
			if (start && !busy) begin
				oldest_sample = predict_sample(sample_index, amplitude);
				expected_sample_q.push_back(oldest_sample);
				if (oldest_sample.err)
					n_out_of_range++;
				if (oldest_sample.value == 17'd65535 || oldest_sample.value == -17'sd65535)
					n_clamped++;
				mode_hits[cfg_mode]++;
				n_accepted++;
			end
		end
	end

	// watchdog: any transfer on any port resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("FAIL sweep_waveform_sample_generator");
				$finish;
			end
		end
	end

	task automatic queue_sample(input int idx, input int amp);
		sample_req_t req;
		req.idx = IDX_W'(idx);
		req.amp = AMP_W'(amp);
		req.gap = burst_mode ? 0 : $urandom_range(0, 9);
		sample_req_q.push_back(req);
		n_queued++;
	endtask

	// every item taken, every result back, then let the pipeline run dry
	task automatic wait_idle();
		while (n_accepted != n_queued || expected_sample_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	// write transfer followed by a read back of the same register
	task automatic write_register(input logic [ADDR_W-1:0] addr, input int unsigned value);
		logic [DATA_W-1:0] mask;
		mask = (addr == REG_WAVE_MODE) ? 32'h3 :
			(addr == REG_PEAK_CURRENT) ? 32'hFFFF : 32'h1FFF;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
			REG_WAVE_MODE:    cfg_mode = wave_mode_t'(value[1:0]);
			REG_PEAK_CURRENT: cfg_peak = value[PEAK_W-1:0];
			default:          cfg_len = value[LEN_W-1:0];
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (value & mask)) begin
			$error("register %0d read back mismatch: expected %0d, actual %0d",
				addr, value & mask, prdata & mask);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_setting(input wave_mode_t mode, input int peak, input int len);
		wait_idle();
		write_register(REG_WAVE_MODE, mode);
		write_register(REG_PEAK_CURRENT, peak);
		write_register(REG_CYCLE_LENGTH, len);
		n_settings++;
	endtask

	initial begin : stimulus
		int k, p, eff, len, peak, idx, amp;
		for (k = 0; k <= SINE_N; k++)
			quarter_sine[k] = sine_series_q16((u64_t'(k) * HALF_PI_Q30 +
				SINE_N / 2) / SINE_N);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: sine, 1 A, 1024 samples
		// zero phase, quadrant starts, last in-range index, first out-of-range index
		queue_sample(0, 32768);
		queue_sample(256, 32768);
		queue_sample(512, 32768);
		queue_sample(768, 32768);
		queue_sample(1023, 32768);
		queue_sample(1024, 32768);
		queue_sample(4095, 65535);
		queue_sample(100, 0);
		queue_sample(300, 65535);

		// triangle at full peak: clamping at -1 and amplitude above 1.0, midpoint turn
		apply_setting(swsg_pkg::WAVE_TRI, 65535, MAX_CYCLE_SAMPLES);
		queue_sample(0, 65535);
		queue_sample(2047, 32768);
		queue_sample(2048, 32768);
		queue_sample(4095, 65535);
		queue_sample(1024, 1);

		// ramp with a one-sample cycle
		apply_setting(swsg_pkg::WAVE_RAMP, 4096, 1);
		queue_sample(0, 32768);
		queue_sample(1, 32768);

		// zero mode with a length above the maximum, taken as the maximum
		apply_setting(swsg_pkg::WAVE_ZERO, 40000, 8191);
		queue_sample(4095, 65535);
		queue_sample(0, 32768);

		// zero length: everything is out of range
		apply_setting(swsg_pkg::WAVE_SINE, 4096, 0);
		queue_sample(0, 32768);
		queue_sample(4095, 0);

		// zero peak current
		apply_setting(swsg_pkg::WAVE_SINE, 0, 3);
		queue_sample(1, 65535);
		queue_sample(2, 32768);

		// random phases: each mode three times, length extremes, bursts and gaps
		for (p = 0; p < RANDOM_PHASES; p++) begin
			peak = (p == 1) ? 65535 : (p == 6) ? 0 : $urandom_range(0, 65535);
			case (p % 6)
				0: len = $urandom_range(1, 16);
				1: len = MAX_CYCLE_SAMPLES;
				2: len = $urandom_range(MAX_CYCLE_SAMPLES + 1, 8191);
				3: len = $urandom_range(17, MAX_CYCLE_SAMPLES - 1);
				4: len = (p == 4) ? 0 : $urandom_range(1, 64);
				default: len = $urandom_range(1, MAX_CYCLE_SAMPLES - 1);
			endcase
			apply_setting(wave_mode_t'(p % 4), peak, len);
			burst_mode = (p % 3 == 1);
			eff = (len > MAX_CYCLE_SAMPLES) ? MAX_CYCLE_SAMPLES : len;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// sender holds off mid-phase until the pipeline is empty
				if (k == ITEMS_PER_PHASE / 2 && p % 6 == 3)
					wait_idle();
				if (eff == 0 || $urandom_range(0, 7) == 0)
					idx = $urandom_range(0, (1 << IDX_W) - 1);
				else
					idx = $urandom_range(0, eff - 1);
				case ($urandom_range(0, 9))
					0: amp = $urandom_range(0, (1 << AMP_W) - 1);
					1: amp = 32768;
					default: amp = $urandom_range(0, 32768);
				endcase
				queue_sample(idx, amp);
			end
		end

		wait_idle();
		$display("covered %0d samples under %0d register settings, %0d out of range, %0d clamped",
			n_accepted, n_settings, n_out_of_range, n_clamped);
		$display("samples per mode: sine %0d, triangle %0d, ramp %0d, zero %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		if (fail_count == 0)
			$display("PASS sweep_waveform_sample_generator");
		else
			$display("FAIL sweep_waveform_sample_generator");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/swsg_pkg.sv
rtl/core/swsg_phase_div.sv
rtl/core/swsg_wave.sv
rtl/core/swsg_scale.sv
rtl/core/sweep_waveform_sample_generator.sv
rtl/core/swsg_check.sv
tb/tb_sweep_waveform_sample_generator.sv
